>>> rtl/srdm_pkg.sv
// Shared types and constants of the split ring descriptor manager.
// Used by every module of the block but srdm_ram; depends on nothing.
package srdm_pkg;

   localparam int MAX_QUEUE_SIZE = 256;
   localparam int IDX_W = $clog2(MAX_QUEUE_SIZE);
   localparam int QS_W = IDX_W + 1;
   localparam logic [15:0] END_MARK = 16'hFFFF;

   localparam logic [1:0] ACT_ADD  = 2'd0;
   localparam logic [1:0] ACT_GET  = 2'd1;
   localparam logic [1:0] ACT_POST = 2'd2;

   localparam logic [2:0] ST_TAKEN     = 3'd0;
   localparam logic [2:0] ST_PUBLISHED = 3'd1;
   localparam logic [2:0] ST_REJECTED  = 3'd2;
   localparam logic [2:0] ST_RETURNED  = 3'd3;
   localparam logic [2:0] ST_NONE      = 3'd4;
   localparam logic [2:0] ST_POSTED    = 3'd5;

   // Link table word: NEXT flag on top of the 16-bit link.
   localparam int LINK_W = 17;
   // Used ring word: id on top of the length.
   localparam int USED_W = 40;

   typedef struct packed {
      logic [1:0]  action;
      logic        first;     // chain_pos is zero
      logic        last;      // chain_pos + 1 >= chain_count
      logic        bad_count; // chain_count zero
      logic [8:0]  count;
      logic [7:0]  used_id;
      logic [31:0] used_len;
   } cmd_type;

   typedef struct packed {
      logic [2:0]  status;
      logic [7:0]  head_index;
      logic [7:0]  got_id;
      logic [31:0] got_len;
      logic [15:0] avail_index;
      logic [8:0]  free_count;
   } rsp_type;

endpackage

>>> rtl/srdm_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Depends on nothing.
module srdm_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule

>>> rtl/srdm_front.sv
// Front end: decodes each request and holds it in a two-entry command queue.
// Depends on srdm_pkg.
module srdm_front (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   output logic                  full,
   input  logic [1:0]            req_action,
   input  logic [8:0]            req_chain_count,
   input  logic [7:0]            req_chain_pos,
   input  logic [7:0]            req_used_id,
   input  logic [31:0]           req_used_len,
   output logic                  cmd_valid,
   input  logic                  cmd_take,
   output srdm_pkg::cmd_type     cmd
);
   import srdm_pkg::*;

   cmd_type    slot_ff [2];
   cmd_type    dec;
   logic       wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [1:0] cnt_ff, cnt_in;
   logic       do_push, do_pop;

   always_comb begin
      dec.action    = req_action;
      dec.first     = (req_chain_pos == 8'd0);
      dec.last      = ({1'b0, req_chain_pos} + 9'd1) >= req_chain_count;
      dec.bad_count = (req_chain_count == 9'd0);
      dec.count     = req_chain_count;
      dec.used_id   = req_used_id;
      dec.used_len  = req_used_len;
   end

   assign full      = (cnt_ff == 2'd2);
   assign cmd_valid = (cnt_ff != 2'd0);
   assign cmd       = slot_ff[rd_ptr_ff];
   assign do_push   = push && !full;
   assign do_pop    = cmd_take && cmd_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ do_push;
      rd_ptr_in = rd_ptr_ff ^ do_pop;
      cnt_in    = cnt_ff + {1'b0, do_push} - {1'b0, do_pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         cnt_ff    <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= dec;
      end
   end
endmodule

>>> rtl/srdm_back.sv
// Back end: executes commands against the link table and used ring.
// Depends on srdm_pkg and srdm_ram.
module srdm_back (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_we,
   input  logic [8:0]            csr_wdata,
   input  logic                  cmd_valid,
   output logic                  cmd_take,
   input  srdm_pkg::cmd_type     cmd,
   output logic                  res_valid,
   input  logic                  res_take,
   output srdm_pkg::rsp_type     res
);
   import srdm_pkg::*;

   localparam logic [2:0] S_IDLE    = 3'd0;
   localparam logic [2:0] S_ADD_WR  = 3'd1;
   localparam logic [2:0] S_GET_RD  = 3'd2;
   localparam logic [2:0] S_WALK    = 3'd3;
   localparam logic [2:0] S_WALK_WR = 3'd4;
   localparam logic [2:0] S_EXEC    = 3'd5;

   logic [2:0]        state_ff, state_in;
   cmd_type           cmd_ff, cmd_in;
   logic [QS_W-1:0]   qsize_ff, qsize_in;
   logic [15:0]       avail_idx_ff, avail_idx_in;
   logic [15:0]       dev_idx_ff, dev_idx_in, seen_idx_ff, seen_idx_in;
   logic [IDX_W-1:0]  dev_slot_ff, dev_slot_in, seen_slot_ff, seen_slot_in;
   logic [15:0]       free_head_ff, free_head_in;
   logic [QS_W-1:0]   free_total_ff, free_total_in;
   logic [IDX_W-1:0]  chain_start_ff, chain_start_in;
   logic              refused_ff, refused_in;
   logic [15:0]       cur_ff, cur_in;
   logic [QS_W-1:0]   steps_ff, steps_in;
   logic [7:0]        gid_ff, gid_in;
   logic [31:0]       glen_ff, glen_in;
   logic [MAX_QUEUE_SIZE-1:0] desc_vld_ff, desc_vld_in;
   rsp_type           res_ff, res_in;
   logic              res_vld_ff, res_vld_in;

   logic              link_we;
   logic [IDX_W-1:0]  link_waddr, link_raddr, link_addr;
   logic [LINK_W-1:0] link_wdata, link_rdata;
   logic              used_we;
   logic [USED_W-1:0] used_wdata, used_rdata;
   logic [15:0]       link_old, link_dflt;
   logic              next_old, emit, ok;
   logic [2:0]        status;
   logic [7:0]        head;
   logic [QS_W-1:0]   clamp;

   srdm_ram #(.WIDTH(LINK_W), .DEPTH(MAX_QUEUE_SIZE)) u_link_ram (
      .clock(clock), .wr_en(link_we), .wr_addr(link_waddr), .wr_data(link_wdata),
      .rd_addr(link_raddr), .rd_data(link_rdata));

   // A used slot is always posted before it can be read, so no valid bits.
   srdm_ram #(.WIDTH(USED_W), .DEPTH(MAX_QUEUE_SIZE)) u_used_ram (
      .clock(clock), .wr_en(used_we), .wr_addr(dev_slot_ff), .wr_data(used_wdata),
      .rd_addr(seen_slot_ff), .rd_data(used_rdata));

   // The address whose read data is consumed in the write states.
   assign link_addr = (state_ff == S_ADD_WR) ? free_head_ff[IDX_W-1:0] : cur_ff[IDX_W-1:0];
   assign link_dflt = ({1'b0, link_addr} == qsize_ff - QS_W'(1)) ?
                      END_MARK : 16'({1'b0, link_addr} + QS_W'(1));
   assign link_old  = desc_vld_ff[link_addr] ? link_rdata[15:0] : link_dflt;
   assign next_old  = desc_vld_ff[link_addr] & link_rdata[LINK_W-1];
   assign used_wdata = {cmd_ff.used_id, cmd_ff.used_len};

   always_comb begin
      if (csr_wdata == 9'd0) begin
         clamp = QS_W'(1);
      end else if (csr_wdata > 9'(MAX_QUEUE_SIZE)) begin
         clamp = QS_W'(MAX_QUEUE_SIZE);
      end else begin
         clamp = QS_W'(csr_wdata);
      end
   end

   assign res       = res_ff;
   assign res_valid = res_vld_ff;

   always_comb begin
      state_in       = state_ff;
      cmd_in         = cmd_ff;
      qsize_in       = qsize_ff;
      avail_idx_in   = avail_idx_ff;
      dev_idx_in     = dev_idx_ff;
      seen_idx_in    = seen_idx_ff;
      dev_slot_in    = dev_slot_ff;
      seen_slot_in   = seen_slot_ff;
      free_head_in   = free_head_ff;
      free_total_in  = free_total_ff;
      chain_start_in = chain_start_ff;
      refused_in     = refused_ff;
      cur_in         = cur_ff;
      steps_in       = steps_ff;
      gid_in         = gid_ff;
      glen_in        = glen_ff;
      desc_vld_in    = desc_vld_ff;
      res_vld_in     = res_vld_ff && !res_take;
      cmd_take       = 1'b0;
      link_we        = 1'b0;
      link_waddr     = link_addr;
      link_wdata     = '0;
      link_raddr     = free_head_ff[IDX_W-1:0];
      used_we        = 1'b0;
      emit           = 1'b0;
      ok             = 1'b0;
      status         = ST_REJECTED;
      head           = 8'd0;

      case (state_ff)
         S_IDLE: begin
            if (cmd_valid && !res_vld_ff) begin
               cmd_take = 1'b1;
               cmd_in   = cmd;
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            case (cmd_ff.action)
               ACT_ADD: begin
                  ok = 1'b1;
                  if (cmd_ff.first) begin
                     if (cmd_ff.bad_count || cmd_ff.count > free_total_ff) begin
                        ok = 1'b0;
                     end else begin
                        refused_in     = 1'b0;
                        chain_start_in = free_head_ff[IDX_W-1:0];
                     end
                  end
                  if (ok && ((!cmd_ff.first && refused_ff) || free_total_ff == '0 ||
                             free_head_ff >= 16'(qsize_ff))) begin
                     ok = 1'b0;
                  end
                  if (ok) begin
                     state_in = S_ADD_WR;
                  end else begin
                     refused_in = 1'b1;
                     emit       = 1'b1;
                  end
               end
               ACT_GET: begin
                  if (seen_idx_ff == dev_idx_ff) begin
                     status = ST_NONE;
                     emit   = 1'b1;
                  end else begin
                     seen_idx_in = seen_idx_ff + 16'd1;
                     if (seen_idx_in == 16'd0 ||
                         {1'b0, seen_slot_ff} + QS_W'(1) == qsize_ff) begin
                        seen_slot_in = '0;
                     end else begin
                        seen_slot_in = seen_slot_ff + IDX_W'(1);
                     end
                     state_in = S_GET_RD;
                  end
               end
               ACT_POST: begin
                  used_we    = 1'b1;
                  dev_idx_in = dev_idx_ff + 16'd1;
                  if (dev_idx_in == 16'd0 ||
                      {1'b0, dev_slot_ff} + QS_W'(1) == qsize_ff) begin
                     dev_slot_in = '0;
                  end else begin
                     dev_slot_in = dev_slot_ff + IDX_W'(1);
                  end
                  status = ST_POSTED;
                  emit   = 1'b1;
               end
               default: begin
                  emit = 1'b1;
               end
            endcase
         end
         S_ADD_WR: begin
            link_we                = 1'b1;
            link_wdata             = {!cmd_ff.last, cmd_ff.last ? 16'd0 : link_old};
            desc_vld_in[link_addr] = 1'b1;
            free_head_in           = link_old;
            free_total_in          = free_total_ff - QS_W'(1);
            head                   = chain_start_ff;
            if (cmd_ff.last) begin
               avail_idx_in = avail_idx_ff + 16'd1;
               refused_in   = 1'b1;
               status       = ST_PUBLISHED;
            end else begin
               status = ST_TAKEN;
            end
            emit = 1'b1;
         end
         S_GET_RD: begin
            // Slot index was advanced already; the read used the old one.
            gid_in   = used_rdata[USED_W-1:32];
            glen_in  = used_rdata[31:0];
            cur_in   = {8'd0, used_rdata[USED_W-1:32]};
            steps_in = '0;
            state_in = S_WALK;
         end
         S_WALK: begin
            link_raddr = cur_ff[IDX_W-1:0];
            if (cur_ff >= 16'(qsize_ff) || steps_ff > qsize_ff) begin
               status = ST_RETURNED;
               emit   = 1'b1;
            end else begin
               state_in = S_WALK_WR;
            end
         end
         S_WALK_WR: begin
            link_we                = 1'b1;
            link_wdata             = {1'b0, free_head_ff};
            desc_vld_in[link_addr] = 1'b1;
            free_head_in           = cur_ff;
            if (free_total_ff < qsize_ff) begin
               free_total_in = free_total_ff + QS_W'(1);
            end
            steps_in = steps_ff + QS_W'(1);
            cur_in   = link_old;
            if (next_old) begin
               state_in = S_WALK;
            end else begin
               status = ST_RETURNED;
               emit   = 1'b1;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      if (emit) begin
         state_in   = S_IDLE;
         res_vld_in = 1'b1;
      end
      res_in.status      = status;
      res_in.head_index  = head;
      res_in.got_id      = (status == ST_RETURNED) ? gid_ff : 8'd0;
      res_in.got_len     = (status == ST_RETURNED) ? glen_ff : 32'd0;
      res_in.avail_index = avail_idx_in;
      res_in.free_count  = free_total_in;

      if (csr_we) begin
         qsize_in       = clamp;
         free_total_in  = clamp;
         avail_idx_in   = '0;
         dev_idx_in     = '0;
         seen_idx_in    = '0;
         dev_slot_in    = '0;
         seen_slot_in   = '0;
         free_head_in   = '0;
         chain_start_in = '0;
         refused_in     = 1'b0;
         desc_vld_in    = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_IDLE;
         qsize_ff       <= QS_W'(MAX_QUEUE_SIZE);
         free_total_ff  <= QS_W'(MAX_QUEUE_SIZE);
         avail_idx_ff   <= '0;
         dev_idx_ff     <= '0;
         seen_idx_ff    <= '0;
         dev_slot_ff    <= '0;
         seen_slot_ff   <= '0;
         free_head_ff   <= '0;
         chain_start_ff <= '0;
         refused_ff     <= 1'b0;
         desc_vld_ff    <= '0;
         res_vld_ff     <= 1'b0;
      end else begin
         state_ff       <= state_in;
         qsize_ff       <= qsize_in;
         free_total_ff  <= free_total_in;
         avail_idx_ff   <= avail_idx_in;
         dev_idx_ff     <= dev_idx_in;
         seen_idx_ff    <= seen_idx_in;
         dev_slot_ff    <= dev_slot_in;
         seen_slot_ff   <= seen_slot_in;
         free_head_ff   <= free_head_in;
         chain_start_ff <= chain_start_in;
         refused_ff     <= refused_in;
         desc_vld_ff    <= desc_vld_in;
         res_vld_ff     <= res_vld_in;
      end
      cmd_ff   <= cmd_in;
      cur_ff   <= cur_in;
      steps_ff <= steps_in;
      gid_ff   <= gid_in;
      glen_ff  <= glen_in;
      if (emit) begin
         res_ff <= res_in;
      end
   end
endmodule

>>> rtl/split_ring_descriptor_manager_unit.sv
// Top level of the split ring descriptor manager.
// Depends on srdm_pkg, srdm_front, srdm_back and srdm_ram.

// The block keeps the driver side of a split descriptor ring: a descriptor
// link table whose unused entries form a free chain, and a used ring filled
// by post requests. Requests enter through a queue-like port (push/full) and
// results leave through another (empty/pop); one result comes back for each
// request, in order. A two-entry command queue between the decoder and the
// execution engine lets the input side keep accepting while a result waits.
// The link table RAM has one write port and one registered read port. A get
// that returns a used chain reads the used ring, then walks the chain one
// descriptor at a time, reading each link and writing the entry back onto the
// free chain; the walk also stops at an index outside the ring.
// Each result is held in a register until it is popped.
// Writing queue_size (clamped to 1..256) rebuilds the free chain at once
// through per-entry valid bits, so no clearing pass is needed; write it only
// while no request is in flight.
module split_ring_descriptor_manager_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        push,
   output logic        full,
   input  logic [1:0]  req_action,
   input  logic [63:0] req_buf_addr,
   input  logic [31:0] req_buf_len,
   input  logic        req_buf_writable,
   input  logic [8:0]  req_chain_count,
   input  logic [7:0]  req_chain_pos,
   input  logic [7:0]  req_used_id,
   input  logic [31:0] req_used_len,
   output logic        empty,
   input  logic        pop,
   output logic [2:0]  rsp_status,
   output logic [7:0]  rsp_head_index,
   output logic [7:0]  rsp_got_id,
   output logic [31:0] rsp_got_len,
   output logic [15:0] rsp_avail_index,
   output logic [8:0]  rsp_free_count,
   input  logic        csr_we,
   input  logic [8:0]  csr_wdata
);
   import srdm_pkg::*;

   cmd_type cmd;
   rsp_type res;
   logic    cmd_valid, cmd_take, res_valid;

   // Buffer address, length and write flag do not affect any result.
   srdm_front u_front (
      .clock(clock), .reset(reset), .push(push), .full(full),
      .req_action(req_action), .req_chain_count(req_chain_count),
      .req_chain_pos(req_chain_pos), .req_used_id(req_used_id),
      .req_used_len(req_used_len), .cmd_valid(cmd_valid), .cmd_take(cmd_take),
      .cmd(cmd));

   srdm_back u_back (
      .clock(clock), .reset(reset), .csr_we(csr_we), .csr_wdata(csr_wdata),
      .cmd_valid(cmd_valid), .cmd_take(cmd_take), .cmd(cmd),
      .res_valid(res_valid), .res_take(pop), .res(res));

   assign empty           = !res_valid;
   assign rsp_status      = res.status;
   assign rsp_head_index  = res.head_index;
   assign rsp_got_id      = res.got_id;
   assign rsp_got_len     = res.got_len;
   assign rsp_avail_index = res.avail_index;
   assign rsp_free_count  = res.free_count;
endmodule

>>> tb/split_ring_descriptor_manager_unit_test.sv
// Self-checking testbench for split_ring_descriptor_manager_unit.
// Depends on srdm_pkg and the RTL of the block; carries its own ring predictor.
module split_ring_descriptor_manager_unit_test;
   timeunit 1ns;
   timeprecision 1ps;
   import srdm_pkg::*;

   localparam int RUN_LIMIT = 8_000_000;
   localparam int ITEMS_PER_PHASE = 245;

   // One request as it is presented on the req_ ports.
   typedef struct {
      logic [1:0]  action;
      logic [63:0] buf_addr;
      logic [31:0] buf_len;
      logic        buf_writable;
      logic [8:0]  chain_count;
      logic [7:0]  chain_pos;
      logic [7:0]  used_id;
      logic [31:0] used_len;
   } request_type;

   logic        clock;
   logic        reset;
   logic        push;
   logic        full;
   logic [1:0]  req_action;
   logic [63:0] req_buf_addr;
   logic [31:0] req_buf_len;
   logic        req_buf_writable;
   logic [8:0]  req_chain_count;
   logic [7:0]  req_chain_pos;
   logic [7:0]  req_used_id;
   logic [31:0] req_used_len;
   logic        empty;
   logic        pop;
   logic [2:0]  rsp_status;
   logic [7:0]  rsp_head_index;
   logic [7:0]  rsp_got_id;
   logic [31:0] rsp_got_len;
   logic [15:0] rsp_avail_index;
   logic [8:0]  rsp_free_count;
   logic        csr_we;
   logic [8:0]  csr_wdata;

   split_ring_descriptor_manager_unit dut (
      .clock(clock), .reset(reset), .push(push), .full(full),
      .req_action(req_action), .req_buf_addr(req_buf_addr), .req_buf_len(req_buf_len),
      .req_buf_writable(req_buf_writable), .req_chain_count(req_chain_count),
      .req_chain_pos(req_chain_pos), .req_used_id(req_used_id),
      .req_used_len(req_used_len), .empty(empty), .pop(pop),
      .rsp_status(rsp_status), .rsp_head_index(rsp_head_index),
      .rsp_got_id(rsp_got_id), .rsp_got_len(rsp_got_len),
      .rsp_avail_index(rsp_avail_index), .rsp_free_count(rsp_free_count),
      .csr_we(csr_we), .csr_wdata(csr_wdata)
   );

   initial clock = 1'b0;
   always #4 clock = ~clock;

   // Requests waiting to be driven, and results the block still owes us.
   request_type request_queue[$];
   rsp_type  owed_results[$];
   int       error_count = 0;
   int       results_seen = 0;
   int       requests_sent = 0;

   // ---------------------------------------------------------------------
   // Ring predictor. Only the state that can reach a result is mirrored:
   // buffer addresses, lengths, the WRITE flag and the available ring itself
   // never show up on the result ports, so they are not kept here.
   // ---------------------------------------------------------------------
   logic [15:0] link_table[MAX_QUEUE_SIZE];
   logic        next_flag[MAX_QUEUE_SIZE];
   logic [7:0]  used_id_ring[MAX_QUEUE_SIZE];
   logic [31:0] used_len_ring[MAX_QUEUE_SIZE];
   logic [15:0] avail_idx, device_idx, seen_idx, free_head, chain_head;
   int unsigned free_total, ring_size;
   bit          chain_refused;
   // Heads of published chains, used by the stimulus to post real completions.
   logic [7:0]  published_heads[$];

   function automatic void rebuild_ring(int unsigned size);
      ring_size = size;
      for (int i = 0; i < MAX_QUEUE_SIZE; i++) begin
         link_table[i] = 16'(i + 1);
         next_flag[i] = 1'b0;
         used_id_ring[i] = '0;
         used_len_ring[i] = '0;
      end
      link_table[size - 1] = END_MARK;
      avail_idx = '0;
      device_idx = '0;
      seen_idx = '0;
      free_head = '0;
      free_total = size;
      chain_head = '0;
      chain_refused = 1'b0;
      published_heads.delete();
   endfunction

   // Walks a returned chain back onto the free list. The walk stops at an
   // index outside the ring or at an entry without NEXT, and it is bounded
   // so a corrupted chain cannot loop forever.
   function automatic void recycle_chain(logic [7:0] id);
      int unsigned d;
      logic [15:0] follow;
      logic        more;
      d = id;
      for (int unsigned steps = 0; steps <= ring_size; steps++) begin
         if (d >= ring_size) break;
         follow = link_table[d];
         more = next_flag[d];
         next_flag[d] = 1'b0;
         link_table[d] = free_head;
         free_head = 16'(d);
         if (free_total < ring_size) free_total++;
         if (!more) break;
         d = follow;
      end
   endfunction

   function automatic void ring_predict(request_type rq);
      rsp_type     r;
      bit          ok, last;
      int unsigned d, slot;
      r = '0;
      r.status = ST_REJECTED;
      case (rq.action)
         ACT_ADD: begin
            ok = 1'b1;
            if (rq.chain_pos == 0) begin
               if (rq.chain_count == 0 || rq.chain_count > free_total) ok = 1'b0;
               else begin
                  chain_refused = 1'b0;
                  chain_head = free_head;
               end
            end
            if (ok && (chain_refused || free_total == 0 || free_head >= ring_size)) ok = 1'b0;
            if (!ok) chain_refused = 1'b1;
            else begin
               d = free_head;
               last = (int'(rq.chain_pos) + 1) >= int'(rq.chain_count);
               next_flag[d] = !last;
               free_head = link_table[d];
               free_total--;
               r.head_index = chain_head[7:0];
               if (last) begin
                  link_table[d] = '0;
                  avail_idx++;
                  chain_refused = 1'b1;
                  published_heads.push_back(chain_head[7:0]);
                  r.status = ST_PUBLISHED;
               end else r.status = ST_TAKEN;
            end
         end
         ACT_GET: begin
            if (seen_idx == device_idx) r.status = ST_NONE;
            else begin
               slot = int'(seen_idx) % ring_size;
               r.got_id = used_id_ring[slot];
               r.got_len = used_len_ring[slot];
               seen_idx++;
               recycle_chain(r.got_id);
               r.status = ST_RETURNED;
            end
         end
         ACT_POST: begin
            // No overflow check: an unread slot is simply overwritten.
            slot = int'(device_idx) % ring_size;
            used_id_ring[slot] = rq.used_id;
            used_len_ring[slot] = rq.used_len;
            device_idx++;
            r.status = ST_POSTED;
         end
         default: ;
      endcase
      r.avail_index = avail_idx;
      r.free_count = 9'(free_total);
      owed_results.push_back(r);
   endfunction

   // ---------------------------------------------------------------------
   // Idle lengths: mostly short, now and then long, and whole stretches of
   // back-to-back traffic where the gap is forced to zero.
   // ---------------------------------------------------------------------
   function automatic int pick_gap(int phase_count);
      int r;
      if (((phase_count / 80) % 3) == 0) return 0;
      r = $urandom_range(99);
      if (r < 45) return 0;
      if (r < 85) return $urandom_range(3, 1);
      if (r < 97) return $urandom_range(10, 4);
      return $urandom_range(60, 20);
   endfunction

   // Driver: presents the head of request_queue and predicts each accepted
   // request at the edge that takes it.
   int send_gap;
   always @(posedge clock) begin
      if (reset) begin
         push <= 1'b0;
         send_gap = 0;
      end else begin
         if (push && !full) begin
            ring_predict(request_queue.pop_front());
            requests_sent++;
            send_gap = pick_gap(requests_sent);
         end
         if (!push || !full) begin
            if (send_gap > 0) begin
               send_gap--;
               push <= 1'b0;
            end else if (request_queue.size() > 0) begin
               req_action <= request_queue[0].action;
               req_buf_addr <= request_queue[0].buf_addr;
               req_buf_len <= request_queue[0].buf_len;
               req_buf_writable <= request_queue[0].buf_writable;
               req_chain_count <= request_queue[0].chain_count;
               req_chain_pos <= request_queue[0].chain_pos;
               req_used_id <= request_queue[0].used_id;
               req_used_len <= request_queue[0].used_len;
               push <= 1'b1;
            end else push <= 1'b0;
         end
      end
   end

   task automatic report_mismatch(string what, longint unsigned got, longint unsigned want);
      $display("mismatch at result %0d: %s got 0x%0h, wanted 0x%0h",
               results_seen, what, got, want);
      error_count++;
   endtask

   // Long hold-off on the result side, timed in its own process. While it
   // lasts the driver keeps offering requests, so the block fills and stalls.
   int  hold_cycles;
   bit  hold_done;
   always @(posedge clock) begin
      if (reset) begin
         hold_cycles <= 0;
         hold_done <= 1'b0;
      end else if (hold_cycles > 0) hold_cycles <= hold_cycles - 1;
      else if (!hold_done && results_seen >= 400) begin
         hold_cycles <= 2000;
         hold_done <= 1'b1;
      end
   end

   // Monitor: takes results and compares each one with the oldest prediction.
   int      take_gap;
   rsp_type want;
   always @(posedge clock) begin
      if (reset) begin
         pop <= 1'b0;
         take_gap = 0;
      end else begin
         if (pop && !empty) begin
            if (owed_results.size() == 0) begin
               report_mismatch("unexpected result, status", rsp_status, 0);
            end else begin
               want = owed_results.pop_front();
               if (rsp_status !== want.status)
                  report_mismatch("status", rsp_status, want.status);
               if (rsp_head_index !== want.head_index)
                  report_mismatch("head_index", rsp_head_index, want.head_index);
               if (rsp_got_id !== want.got_id)
                  report_mismatch("got_id", rsp_got_id, want.got_id);
               if (rsp_got_len !== want.got_len)
                  report_mismatch("got_len", rsp_got_len, want.got_len);
               if (rsp_avail_index !== want.avail_index)
                  report_mismatch("avail_index", rsp_avail_index, want.avail_index);
               if (rsp_free_count !== want.free_count)
                  report_mismatch("free_count", rsp_free_count, want.free_count);
            end
            results_seen++;
            take_gap = pick_gap(results_seen + 40);
         end
         if (hold_cycles > 0) pop <= 1'b0;
         else if (take_gap > 0) begin
            take_gap--;
            pop <= 1'b0;
         end else pop <= 1'b1;
      end
   end

   // Watchdog: any hang ends the run as a failure.
   int cycle_count = 0;
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > RUN_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

   // ---------------------------------------------------------------------
   // Stimulus helpers. Every field gets random content; the ones that the
   // action uses are then set on purpose.
   // ---------------------------------------------------------------------
   function automatic request_type random_request(logic [1:0] act);
      request_type rq;
      rq.action = act;
      rq.buf_addr = {$urandom(), $urandom()};
      rq.buf_len = $urandom();
      rq.buf_writable = $urandom_range(1);
      rq.chain_count = $urandom_range(256);
      rq.chain_pos = $urandom_range(255);
      rq.used_id = $urandom_range(255);
      rq.used_len = $urandom();
      return rq;
   endfunction

   // Queues elements of a chain with the given count, at positions from zero up
   // (count may also be illegal, in which case every element is refused).
   function automatic int add_chain(int count, int elements);
      request_type rq;
      for (int p = 0; p < elements; p++) begin
         rq = random_request(ACT_ADD);
         rq.chain_count = 9'(count);
         rq.chain_pos = 8'(p);
         request_queue.push_back(rq);
      end
      return elements;
   endfunction

   function automatic int add_single(logic [1:0] act);
      request_queue.push_back(random_request(act));
      return 1;
   endfunction

   function automatic int add_post(logic [7:0] id, logic [31:0] len);
      request_type rq;
      rq = random_request(ACT_POST);
      rq.used_id = id;
      rq.used_len = len;
      request_queue.push_back(rq);
      return 1;
   endfunction

   // One random sequence: mostly real traffic (chains, completions of chains
   // that were published, gets), the rest malformed or out-of-range requests.
   function automatic int add_random_sequence();
      int r, count, pick;
      logic [7:0] id;
      r = $urandom_range(99);
      if (r < 42) begin
         if ($urandom_range(99) < 4) count = $urandom_range(ring_size, 1);
         else count = $urandom_range(4, 1);
         return add_chain(count, count);
      end else if (r < 62) begin
         if (published_heads.size() > 0 && $urandom_range(99) < 85) begin
            pick = $urandom_range(published_heads.size() - 1);
            id = published_heads[pick];
            published_heads.delete(pick);
         end else id = $urandom_range(255);
         return add_post(id, $urandom());
      end else if (r < 82) begin
         return add_single(ACT_GET);
      end else if (r < 86) begin
         // A chain whose count is zero or larger than what is free.
         count = ($urandom_range(1) == 0) ? 0 : $urandom_range(256, free_total + 1);
         return add_chain(count, $urandom_range(3, 1));
      end else if (r < 91) begin
         // A lone first element with a random count, then an add at a random position.
         return add_chain($urandom_range(256), 1) + add_single(ACT_ADD);
      end else if (r < 96) begin
         // A chain cut short; the next chain starts over at position zero.
         count = $urandom_range(6, 2);
         return add_chain(count, $urandom_range(count - 1, 1));
      end
      return add_single(2'd3);
   endfunction

   task automatic wait_drained();
      while (request_queue.size() > 0 || owed_results.size() > 0 || push)
         @(posedge clock);
      // An idle block owes nothing more, but give a long chain walk time to end.
      repeat (600) @(posedge clock);
   endtask

   task automatic write_queue_size(logic [8:0] value);
      int unsigned size;
      @(posedge clock);
      csr_we <= 1'b1;
      csr_wdata <= value;
      size = (value == 0) ? 1 : (value > MAX_QUEUE_SIZE ? MAX_QUEUE_SIZE : value);
      rebuild_ring(size);
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   // Queue sizes per phase, the first one being the size after reset.
   // Zero and values above the maximum are clamped by the block.
   int phase_sizes[8] = '{256, 0, 3, 16, 511, 200, 2, 8};
   int queued;
   request_type rq;

   initial begin
      reset = 1'b1;
      push = 1'b0;
      pop = 1'b0;
      csr_we = 1'b0;
      csr_wdata = '0;
      req_action = ACT_ADD;
      req_buf_addr = '0;
      req_buf_len = '0;
      req_buf_writable = 1'b0;
      req_chain_count = '0;
      req_chain_pos = '0;
      req_used_id = '0;
      req_used_len = '0;
      rebuild_ring(MAX_QUEUE_SIZE);
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // Directed opening: a refused zero count, a first element of a full-ring chain, extreme fields, an empty get,
      // a stray continuation, the unknown action and a full round trip.
      queued = add_chain(0, 1);
      queued += add_chain(256, 1);
      queued += add_single(ACT_GET);
      rq = random_request(ACT_ADD);
      rq.buf_addr = '1;
      rq.buf_len = '1;
      rq.buf_writable = 1'b1;
      rq.chain_count = 9'd1;
      rq.chain_pos = 8'd0;
      request_queue.push_back(rq);
      rq.chain_pos = 8'd255;
      request_queue.push_back(rq);
      queued += add_chain(3, 3);
      queued += add_post(8'd0, 32'hFFFF_FFFF);
      queued += add_post(8'd1, 32'd0);
      queued += add_single(ACT_GET);
      queued += add_single(ACT_GET);
      queued += add_single(ACT_GET);
      queued += add_single(2'd3);
      queued += add_chain(4, 2);
      queued += add_chain(2, 2);
      queued += 2;

      for (int ph = 0; ph < 8; ph++) begin
         if (ph > 0) begin
            wait_drained();
            write_queue_size(9'(phase_sizes[ph]));
            queued = 0;
            // Overfill the used ring once so that unread slots get overwritten.
            if (ph == 2) for (int k = 0; k < 5; k++) queued += add_post($urandom_range(255), $urandom());
         end
         while (queued < ITEMS_PER_PHASE) begin
            while (request_queue.size() >= 4) @(posedge clock);
            queued += add_random_sequence();
         end
      end
      wait_drained();

      if (error_count == 0) $display("Simulation PASSED");
      else $display("Simulation FAILED");
      $finish;
   end

endmodule
